// ----- rtl/proximity_motor_mixer_defines.svh -----
// assertion macros of the mixer rtl
`ifndef PROXIMITY_MOTOR_MIXER_DEFINES_SVH
`define PROXIMITY_MOTOR_MIXER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pmm_pkg.sv -----
// types, widths and constants of the proximity motor mixer
package pmm_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int RDG_W        = 12;
  localparam int REQ_W        = 16;
  localparam int PROD_W       = 20;   // reading times one weight
  localparam int SUM_W        = 22;   // weighted sum of all readings
  localparam int MAG_W        = 21;
  localparam int TOTAL_W      = 15;
  localparam int LIMIT_W      = 10;
  localparam int GAIN_W       = 4;
  localparam int BIAS_W       = 8;
  localparam int THR_W        = 15;
  localparam int OUT_W        = 11;
  localparam int QW           = 10;   // limiter quotient bits
  localparam int MAG2_W       = 17;   // wheel magnitude before limiting
  localparam int NUM_W        = MAG2_W + LIMIT_W;
  localparam int DSH_W        = MAG2_W + QW - 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 15;

  // divide by 350 via reciprocal: estimate is exact or one low
  localparam int SENSOR_DIV   = 350;
  localparam int RECIP_SH     = 21;
  localparam int RECIP_W      = 13;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / SENSOR_DIV);
  localparam int QE_W         = MAG_W + RECIP_W - RECIP_SH;
  localparam int Q_W          = 12;
  localparam int TERM_W       = 13;
  localparam int SLOW_SH      = 13;   // slow-down divides by 8192
  localparam int SP_W         = REQ_W + RDG_W + 1;
  localparam int MIX_W        = 18;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = LIMIT_W'(1000);
  localparam logic [GAIN_W-1:0]  SENSOR_GAIN_RST = GAIN_W'(10);
  localparam logic [BIAS_W-1:0]  LEFT_BIAS_RST   = BIAS_W'(66);
  localparam logic [BIAS_W-1:0]  RIGHT_BIAS_RST  = BIAS_W'(72);
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(2800);

  typedef logic signed [7:0] weight_t;

  localparam weight_t WEIGHT_R [SENSOR_COUNT] = '{
    8'sd17, 8'sd29, 8'sd34, 8'sd10, 8'sd8, -8'sd38, -8'sd56, -8'sd76
  };
  localparam weight_t WEIGHT_L [SENSOR_COUNT] = '{
    -8'sd72, -8'sd58, -8'sd36, 8'sd8, 8'sd10, 8'sd36, 8'sd28, 8'sd18
  };

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [RDG_W-1:0]         rdg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT  = 3'd0,
    CFG_SENSOR_GAIN  = 3'd1,
    CFG_LEFT_BIAS    = 3'd2,
    CFG_RIGHT_BIAS   = 3'd3,
    CFG_PROX_THRESH  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_l;
    logic [TOTAL_W-1:0]      total;
    logic [RDG_W-1:0]        peak;
  } merge_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem_l;
    logic [NUM_W-1:0] rem_r;
    logic [DSH_W-1:0] dsh;
    logic [QW-1:0]    q_l;
    logic [QW-1:0]    q_r;
    logic             over;
    logic             neg_l;
    logic             neg_r;
    logic [OUT_W-1:0] pass_l;
    logic [OUT_W-1:0] pass_r;
  } div_t;

endpackage

// ----- rtl/pmm_lane.sv -----
// one sensor lane: reading times its left and right weights
module pmm_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  pmm_pkg::rdg_t     rdg_i,
  input  pmm_pkg::weight_t  w_r_i,
  input  pmm_pkg::weight_t  w_l_i,
  output pmm_pkg::rdg_t     rdg_o,
  output pmm_pkg::prod_t    prod_r_o,
  output pmm_pkg::prod_t    prod_l_o
);
  import pmm_pkg::*;

  logic signed [PROD_W:0] full_r;
  logic signed [PROD_W:0] full_l;
  prod_t prod_r_q, prod_l_q;
  rdg_t  rdg_q;

  assign full_r = $signed({1'b0, rdg_i}) * w_r_i;
  assign full_l = $signed({1'b0, rdg_i}) * w_l_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_r_q <= full_r[PROD_W-1:0];
      prod_l_q <= full_l[PROD_W-1:0];
      rdg_q    <= rdg_i;
    end
  end

  assign prod_r_o = prod_r_q;
  assign prod_l_o = prod_l_q;
  assign rdg_o    = rdg_q;

endmodule

// ----- rtl/pmm_merge.sv -----
// merges the lanes: weighted sums, reading total and peak reading
module pmm_merge (
  input  logic            clk_i,
  input  logic            en_i,
  input  pmm_pkg::prod_t  prod_r_i [pmm_pkg::SENSOR_COUNT],
  input  pmm_pkg::prod_t  prod_l_i [pmm_pkg::SENSOR_COUNT],
  input  pmm_pkg::rdg_t   rdg_i    [pmm_pkg::SENSOR_COUNT],
  output pmm_pkg::merge_t merge_o
);
  import pmm_pkg::*;

  merge_t merge_d, merge_q;

  always_comb begin
    merge_d = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      merge_d.sum_r = merge_d.sum_r + SUM_W'(prod_r_i[i]);
      merge_d.sum_l = merge_d.sum_l + SUM_W'(prod_l_i[i]);
      merge_d.total = merge_d.total + TOTAL_W'(rdg_i[i]);
      if (rdg_i[i] > merge_d.peak) begin
        merge_d.peak = rdg_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

// ----- rtl/pmm_div_step.sv -----
// one restoring step of the limiter divide, both wheels
module pmm_div_step (
  input  logic          clk_i,
  input  logic          en_i,
  input  pmm_pkg::div_t div_i,
  output pmm_pkg::div_t div_o
);
  import pmm_pkg::*;

  div_t             div_d, div_q;
  logic [NUM_W-1:0] dsh_ext;
  logic             take_l, take_r;

  assign dsh_ext = NUM_W'(div_i.dsh);
  assign take_l  = div_i.rem_l >= dsh_ext;
  assign take_r  = div_i.rem_r >= dsh_ext;

  always_comb begin
    div_d       = div_i;
    div_d.rem_l = take_l ? div_i.rem_l - dsh_ext : div_i.rem_l;
    div_d.rem_r = take_r ? div_i.rem_r - dsh_ext : div_i.rem_r;
    div_d.q_l   = {div_i.q_l[QW-2:0], take_l};
    div_d.q_r   = {div_i.q_r[QW-2:0], take_r};
    div_d.dsh   = div_i.dsh >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ----- rtl/proximity_motor_mixer.sv -----
// throughput: one beat per cycle unless the output stalls, every stage fully pipelined;
// the depth is mostly the ten one-bit stages of the limiter divide and the reciprocal divide by 350
// each stage advances on its own when the next one is free, so bubbles collapse
// reset clears all stage valid flags and loads the register defaults; no clearing pass
module proximity_motor_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [pmm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pmm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // sensor_0..sensor_7 (12b each), left_request, right_request (16b signed)
  input  logic [127:0]                        s_axis_tdata_i,
  // output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // left_speed, right_speed (11b signed each), 2 zero pad bits
  output logic [23:0]                         m_axis_tdata_o
);
  import pmm_pkg::*;
  `include "proximity_motor_mixer_defines.svh"

  localparam int NST     = 17;         // pipeline stages
  localparam int DIV_ST0 = 6;          // stage that loads the divider
  localparam int REQ_LSB = SENSOR_COUNT * RDG_W;

  // ---------------------------------------------------------------- config
  logic [LIMIT_W-1:0] limit_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [BIAS_W-1:0]  bias_l_q, bias_r_q;
  logic [THR_W-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= SPEED_LIMIT_RST;
      gain_q   <= SENSOR_GAIN_RST;
      bias_l_q <= LEFT_BIAS_RST;
      bias_r_q <= RIGHT_BIAS_RST;
      thr_q    <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPEED_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_SENSOR_GAIN: gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_LEFT_BIAS:   bias_l_q <= cfg_data_i[BIAS_W-1:0];
        CFG_RIGHT_BIAS:  bias_r_q <= cfg_data_i[BIAS_W-1:0];
        CFG_PROX_THRESH: thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // stage k loads when it is empty or everything behind it can move
  logic [NST:1]   v_q, v_d;
  logic [NST:1]   en;
  logic           s_fire, m_fire;

  for (genvar k = 1; k <= NST; k++) begin : g_en
    assign en[k] = m_axis_tready_i || !(&v_q[NST:k]);
  end

  always_comb begin
    v_d = v_q;
    if (en[1]) begin
      v_d[1] = s_axis_tvalid_i;
    end
    for (int k = 2; k <= NST; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[NST];
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;

  // ---------------------------------------------------------------- stage 1: lanes
  prod_t prod_r [SENSOR_COUNT];
  prod_t prod_l [SENSOR_COUNT];
  rdg_t  rdg    [SENSOR_COUNT];

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    pmm_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en[1]),
      .rdg_i    (s_axis_tdata_i[i*RDG_W +: RDG_W]),
      .w_r_i    (WEIGHT_R[i]),
      .w_l_i    (WEIGHT_L[i]),
      .rdg_o    (rdg[i]),
      .prod_r_o (prod_r[i]),
      .prod_l_o (prod_l[i])
    );
  end

  logic signed [REQ_W-1:0] req1_l_q, req1_r_q, req2_l_q, req2_r_q, req3_l_q, req3_r_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      req1_l_q <= $signed(s_axis_tdata_i[REQ_LSB +: REQ_W]);
      req1_r_q <= $signed(s_axis_tdata_i[REQ_LSB+REQ_W +: REQ_W]);
    end
    if (en[2]) begin
      req2_l_q <= req1_l_q;
      req2_r_q <= req1_r_q;
    end
  end

  // ---------------------------------------------------------------- stage 2: merge
  merge_t mg;

  pmm_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en[2]),
    .prod_r_i (prod_r),
    .prod_l_i (prod_l),
    .rdg_i    (rdg),
    .merge_o  (mg)
  );

  // ---------------------------------------------------------------- stage 3
  // magnitudes of the weighted sums times the reciprocal of 350,
  // slow-down product request*peak
  logic [SUM_W-1:0]            abs_r, abs_l;
  logic [MAG_W+RECIP_W-1:0]    qp_r, qp_l;
  logic signed [SP_W-1:0]      sp_l_d, sp_r_d;
  logic [MAG_W-1:0]            mag3_r_q, mag3_l_q;
  logic [QE_W-1:0]             qe3_r_q, qe3_l_q;
  logic                        neg3_r_q, neg3_l_q, slow3_q;
  logic signed [SP_W-1:0]      sp3_l_q, sp3_r_q;

  assign abs_r  = mg.sum_r[SUM_W-1] ? -mg.sum_r : mg.sum_r;
  assign abs_l  = mg.sum_l[SUM_W-1] ? -mg.sum_l : mg.sum_l;
  assign qp_r   = abs_r[MAG_W-1:0] * RECIP;
  assign qp_l   = abs_l[MAG_W-1:0] * RECIP;
  assign sp_l_d = req2_l_q * $signed({1'b0, mg.peak});
  assign sp_r_d = req2_r_q * $signed({1'b0, mg.peak});

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mag3_r_q <= abs_r[MAG_W-1:0];
      mag3_l_q <= abs_l[MAG_W-1:0];
      qe3_r_q  <= qp_r[RECIP_SH +: QE_W];
      qe3_l_q  <= qp_l[RECIP_SH +: QE_W];
      neg3_r_q <= mg.sum_r[SUM_W-1];
      neg3_l_q <= mg.sum_l[SUM_W-1];
      slow3_q  <= mg.total > thr_q;   // strictly above the threshold
      sp3_l_q  <= sp_l_d;
      sp3_r_q  <= sp_r_d;
      req3_l_q <= req2_l_q;
      req3_r_q <= req2_r_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // fix the quotient estimate, apply sign and bias; apply the slow-down
  logic [MAG_W:0]              q350_r, q350_l, rem_r, rem_l;
  logic [QE_W-1:0]             q_r_full, q_l_full;
  logic signed [TERM_W-1:0]    qs_r, qs_l, term_r_d, term_l_d;
  logic signed [SP_W-1:0]      spa_l, spa_r, shr_l, shr_r;
  logic signed [REQ_W-1:0]     ls_d, rs_d;
  logic signed [TERM_W-1:0]    term4_r_q, term4_l_q;
  logic signed [REQ_W-1:0]     ls4_q, rs4_q;

  assign q350_r   = qe3_r_q * (MAG_W+1)'(SENSOR_DIV);
  assign q350_l   = qe3_l_q * (MAG_W+1)'(SENSOR_DIV);
  assign rem_r    = {1'b0, mag3_r_q} - q350_r;
  assign rem_l    = {1'b0, mag3_l_q} - q350_l;
  assign q_r_full = qe3_r_q + QE_W'(rem_r >= (MAG_W+1)'(SENSOR_DIV));
  assign q_l_full = qe3_l_q + QE_W'(rem_l >= (MAG_W+1)'(SENSOR_DIV));
  assign qs_r     = neg3_r_q ? -$signed({1'b0, q_r_full[Q_W-1:0]})
                             :  $signed({1'b0, q_r_full[Q_W-1:0]});
  assign qs_l     = neg3_l_q ? -$signed({1'b0, q_l_full[Q_W-1:0]})
                             :  $signed({1'b0, q_l_full[Q_W-1:0]});
  assign term_r_d = qs_r + $signed({{(TERM_W-BIAS_W){1'b0}}, bias_r_q});
  assign term_l_d = qs_l + $signed({{(TERM_W-BIAS_W){1'b0}}, bias_l_q});

  // divide by 8192 toward zero: bias negative products before the shift
  assign spa_l = sp3_l_q[SP_W-1] ? sp3_l_q + SP_W'(2 ** SLOW_SH - 1) : sp3_l_q;
  assign spa_r = sp3_r_q[SP_W-1] ? sp3_r_q + SP_W'(2 ** SLOW_SH - 1) : sp3_r_q;
  assign shr_l = spa_l >>> SLOW_SH;
  assign shr_r = spa_r >>> SLOW_SH;
  assign ls_d  = slow3_q ? req3_l_q - $signed(shr_l[REQ_W-1:0]) : req3_l_q;
  assign rs_d  = slow3_q ? req3_r_q - $signed(shr_r[REQ_W-1:0]) : req3_r_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      term4_r_q <= term_r_d;
      term4_l_q <= term_l_d;
      ls4_q     <= ls_d;
      rs4_q     <= rs_d;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // add gain times sensor term to each request
  logic signed [MIX_W-1:0] gt_l, gt_r, mix_l_d, mix_r_d, mix5_l_q, mix5_r_q;

  assign gt_l    = $signed({1'b0, gain_q}) * term4_l_q;
  assign gt_r    = $signed({1'b0, gain_q}) * term4_r_q;
  assign mix_l_d = $signed({{(MIX_W-REQ_W){ls4_q[REQ_W-1]}}, ls4_q}) + gt_l;
  assign mix_r_d = $signed({{(MIX_W-REQ_W){rs4_q[REQ_W-1]}}, rs4_q}) + gt_r;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      mix5_l_q <= mix_l_d;
      mix5_r_q <= mix_r_d;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // limiter setup: over-limit check, larger magnitude, numerators |x|*limit
  logic [MIX_W-1:0]  mabs_l, mabs_r;
  logic [MAG2_W-1:0] ml, mr, big, lim_ext;
  div_t              div6_d, div6_q;
  div_t              div_q [QW+1];

  assign mabs_l  = mix5_l_q[MIX_W-1] ? -mix5_l_q : mix5_l_q;
  assign mabs_r  = mix5_r_q[MIX_W-1] ? -mix5_r_q : mix5_r_q;
  assign ml      = mabs_l[MAG2_W-1:0];
  assign mr      = mabs_r[MAG2_W-1:0];
  assign lim_ext = MAG2_W'(limit_q);
  assign big     = (ml > mr) ? ml : mr;

  always_comb begin
    div6_d        = '0;
    div6_d.rem_l  = ml * limit_q;
    div6_d.rem_r  = mr * limit_q;
    div6_d.dsh    = {big, {(QW-1){1'b0}}};
    div6_d.over   = (ml > lim_ext) || (mr > lim_ext);
    div6_d.neg_l  = mix5_l_q[MIX_W-1];
    div6_d.neg_r  = mix5_r_q[MIX_W-1];
    div6_d.pass_l = mix5_l_q[OUT_W-1:0];
    div6_d.pass_r = mix5_r_q[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[DIV_ST0]) begin
      div6_q <= div6_d;
    end
  end

  assign div_q[0] = div6_q;

  // ---------------------------------------------------------------- stages 7..16
  // restoring divide, one quotient bit per stage, msb first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    pmm_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en[DIV_ST0+k]),
      .div_i (div_q[k-1]),
      .div_o (div_q[k])
    );
  end

  // ---------------------------------------------------------------- stage 17: output
  logic [OUT_W-1:0] qx_l, qx_r, out_l_d, out_r_d, out_l_q, out_r_q;

  assign qx_l    = {1'b0, div_q[QW].q_l};
  assign qx_r    = {1'b0, div_q[QW].q_r};
  assign out_l_d = !div_q[QW].over ? div_q[QW].pass_l :
                   div_q[QW].neg_l ? -qx_l : qx_l;
  assign out_r_d = !div_q[QW].over ? div_q[QW].pass_r :
                   div_q[QW].neg_r ? -qx_r : qx_r;

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      out_l_q <= out_l_d;
      out_r_q <= out_r_d;
    end
  end

  assign m_axis_tdata_o = {2'b00, out_r_q, out_l_q};

  // ---------------------------------------------------------------- checks
  // input only backs up once every stage holds a beat
  `PMM_ASSERT_IMP(a_full_when_blocked, !s_axis_tready_o, &v_q, "input stalled with a bubble inside")
  // a beat taken in and none delivered grows the occupancy by exactly one
  `PMM_ASSERT_NXT(a_count_up, s_fire && !m_fire, $countones(v_q) == $past($countones(v_q)) + 1, "beat lost or duplicated in pipeline")
  // when the limiter result is used, its divisor is never zero
  `PMM_ASSERT_IMP(a_div_nonzero, v_q[DIV_ST0] && div_q[0].over, div_q[0].dsh != '0, "limiter divisor is zero")

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the proximity motor mixer: stream stimulus, predictor, scoreboard
module tb;
  import pmm_pkg::*;

  // tdata layout of the input beat
  localparam int REQ_L_LSB = SENSOR_COUNT * RDG_W;
  localparam int REQ_R_LSB = REQ_L_LSB + REQ_W;
  // slow-down divisor, 8192
  localparam longint SLOW_DIV = longint'(1) << SLOW_SH;
  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] LAST_SPARE_IDX  = 3'd7;
  // random frames per register setting
  localparam int FRAMES_PER_SETTING = 76;

  typedef struct {
    rdg_t                    rdg [SENSOR_COUNT];
    logic signed [REQ_W-1:0] req_l;
    logic signed [REQ_W-1:0] req_r;
  } frame_t;

  typedef struct packed {
    logic [OUT_W-1:0] wheel_r;
    logic [OUT_W-1:0] wheel_l;
  } speed_pair_t;

  // own copy of the registers, the predicted speeds and the mismatch count
  class wheel_speed_board;
    logic [LIMIT_W-1:0] speed_limit;
    logic [GAIN_W-1:0]  gain;
    logic [BIAS_W-1:0]  bias_l;
    logic [BIAS_W-1:0]  bias_r;
    logic [THR_W-1:0]   threshold;
    speed_pair_t        expected_speeds [$];
    int                 mismatches;

    function new();
      speed_limit = SPEED_LIMIT_RST;
      gain        = SENSOR_GAIN_RST;
      bias_l      = LEFT_BIAS_RST;
      bias_r      = RIGHT_BIAS_RST;
      threshold   = THRESHOLD_RST;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      unique case (idx)
        CFG_SPEED_LIMIT: speed_limit = data[LIMIT_W-1:0];
        CFG_SENSOR_GAIN: gain        = data[GAIN_W-1:0];
        CFG_LEFT_BIAS:   bias_l      = data[BIAS_W-1:0];
        CFG_RIGHT_BIAS:  bias_r      = data[BIAS_W-1:0];
        CFG_PROX_THRESH: threshold   = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function speed_pair_t mix_speeds(frame_t f);
      longint      sum_r, sum_l, total, peak, rdg, wl, wr, lim, mag_l, mag_r, big;
      speed_pair_t res;
      sum_r = 0;
      sum_l = 0;
      total = 0;
      peak  = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        rdg   = longint'(f.rdg[i]);
        total = total + rdg;
        if (rdg > peak) peak = rdg;
        sum_r = sum_r + longint'(WEIGHT_R[i]) * rdg;
        sum_l = sum_l + longint'(WEIGHT_L[i]) * rdg;
      end
      // signed longint division truncates toward zero
      sum_l = sum_l / SENSOR_DIV + longint'(bias_l);
      sum_r = sum_r / SENSOR_DIV + longint'(bias_r);
      wl = longint'(f.req_l);
      wr = longint'(f.req_r);
      // strictly above the threshold slows the requests
      if (total > longint'(threshold)) begin
        wl = wl - (wl * peak) / SLOW_DIV;
        wr = wr - (wr * peak) / SLOW_DIV;
      end
      wl = wl + longint'(gain) * sum_l;
      wr = wr + longint'(gain) * sum_r;
      lim   = longint'(speed_limit);
      mag_l = (wl < 0) ? -wl : wl;
      mag_r = (wr < 0) ? -wr : wr;
      if (mag_l > lim || mag_r > lim) begin
        big = (mag_l > mag_r) ? mag_l : mag_r;
        wl  = (wl * lim) / big;
        wr  = (wr * lim) / big;
      end
      res.wheel_l = wl[OUT_W-1:0];
      res.wheel_r = wr[OUT_W-1:0];
      return res;
    endfunction

    function void note_frame(frame_t f);
      expected_speeds.push_back(mix_speeds(f));
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_speeds(logic [23:0] beat);
      speed_pair_t      want;
      logic [OUT_W-1:0] got_l, got_r;
      got_l = beat[OUT_W-1:0];
      got_r = beat[2*OUT_W-1:OUT_W];
      if (expected_speeds.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", beat));
        return;
      end
      want = expected_speeds.pop_front();
      if (got_l !== want.wheel_l)
        report($sformatf("left_speed %0d, expected %0d", $signed(got_l), $signed(want.wheel_l)));
      if (got_r !== want.wheel_r)
        report($sformatf("right_speed %0d, expected %0d", $signed(got_r), $signed(want.wheel_r)));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPEED_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [127:0]          s_data = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [23:0]           m_data;

  wheel_speed_board sb;
  int unsigned      burst_left = 0;
  logic [5:0]       stall_count = '0;
  logic [1:0]       stall_mode = '0;

  proximity_motor_mixer u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: checks each accepted beat, then picks the next ready value;
  // a new stall mode whenever stall_count wraps to zero, mode zero never stalls
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_speeds(m_data);
    stall_count <= stall_count + 6'd1;
    if (stall_count == '0) stall_mode <= 2'($urandom_range(0, 3));
    unique case (stall_mode)
      2'd0:    m_ready <= 1'b1;
      2'd1:    m_ready <= 1'($urandom_range(0, 1));
      2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= (stall_count[1:0] != 2'd3);
    endcase
  end

  function automatic logic [127:0] pack_frame(frame_t f);
    logic [127:0] d;
    d = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) d[i*RDG_W +: RDG_W] = f.rdg[i];
    d[REQ_L_LSB +: REQ_W] = f.req_l;
    d[REQ_R_LSB +: REQ_W] = f.req_r;
    return d;
  endfunction

  function automatic frame_t frame_of(rdg_t fill, int req_l, int req_r);
    frame_t f;
    foreach (f.rdg[i]) f.rdg[i] = fill;
    f.req_l = REQ_W'(req_l);
    f.req_r = REQ_W'(req_r);
    return f;
  endfunction

  // mostly moderate requests so that the limiter does not swallow everything
  function automatic logic signed [REQ_W-1:0] rand_request();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return REQ_W'(int'($urandom_range(0, 2600)) - 1300);
    if (pick < 9) return REQ_W'(int'($urandom_range(0, 18000)) - 9000);
    return REQ_W'($urandom);
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int     others;
    int     need;
    f.req_l = rand_request();
    f.req_r = rand_request();
    case ($urandom_range(0, 3))
      0: foreach (f.rdg[i]) f.rdg[i] = RDG_W'($urandom);
      1: foreach (f.rdg[i]) f.rdg[i] = RDG_W'($urandom_range(0, 150));
      2: begin
        // open space with one or two close obstacles
        foreach (f.rdg[i]) f.rdg[i] = RDG_W'($urandom_range(0, 300));
        f.rdg[$urandom_range(0, SENSOR_COUNT-1)] = RDG_W'($urandom_range(1000, 4095));
        if ($urandom_range(0, 1)) begin
          f.rdg[$urandom_range(0, SENSOR_COUNT-1)] = RDG_W'($urandom_range(1000, 4095));
        end
      end
      default: begin
        // reading sum right at the threshold or one above it, where the other readings allow
        foreach (f.rdg[i]) f.rdg[i] = RDG_W'($urandom);
        others = 0;
        for (int i = 1; i < SENSOR_COUNT; i++) others += int'(f.rdg[i]);
        need = int'(sb.threshold) - others + int'($urandom_range(0, 1));
        if (need >= 0 && need <= 4095) f.rdg[0] = RDG_W'(need);
      end
    endcase
    return f;
  endfunction

  // sender: bursts of random length, random gap before each burst
  task automatic push_frame(frame_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= pack_frame(f);
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_frame(f);
  endtask

  // hold the input until every predicted result has been taken
  task automatic drain_results();
    s_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_speeds.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // empties the pipeline first; ends with a write to an undecoded index
  task automatic reprogram(logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] gain,
                           logic [CFG_DATA_W-1:0] bias_l, logic [CFG_DATA_W-1:0] bias_r,
                           logic [CFG_DATA_W-1:0] thr);
    drain_results();
    cfg_write(CFG_SPEED_LIMIT, lim);
    cfg_write(CFG_SENSOR_GAIN, gain);
    cfg_write(CFG_LEFT_BIAS, bias_l);
    cfg_write(CFG_RIGHT_BIAS, bias_r);
    cfg_write(CFG_PROX_THRESH, thr);
    cfg_write(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, LAST_SPARE_IDX)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic push_random(int count);
    for (int k = 0; k < count; k++) push_frame(rand_frame());
  endtask

  initial begin
    frame_t f;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset settings
    push_frame(frame_of(12'd0, 0, 0));
    push_frame(frame_of(12'hFFF, 32767, 32767));
    push_frame(frame_of(12'hFFF, -32768, -32768));
    push_frame(frame_of(12'd0, 32767, -32768));
    // one close obstacle on each sensor in turn
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      f = frame_of(12'd0, 300, -300);
      f.rdg[i] = 12'hFFF;
      push_frame(f);
    end
    // reading sum equal to the threshold, then one above it
    push_frame(frame_of(12'd350, 500, 400));
    f = frame_of(12'd350, 500, 400);
    f.rdg[0] = 12'd351;
    push_frame(f);
    // equal magnitudes over the limit, same and opposite sign
    push_frame(frame_of(12'd0, 1340, 1280));
    push_frame(frame_of(12'd0, -2660, 1280));
    // both wheels exactly on the limit, no scaling
    push_frame(frame_of(12'd0, 340, 280));
    // alternating bit patterns
    f = frame_of(12'hAAA, 16'h5555, -21846);
    for (int i = 1; i < SENSOR_COUNT; i += 2) f.rdg[i] = 12'h555;
    push_frame(f);
    push_random(FRAMES_PER_SETTING);

    // extremes of every register
    reprogram(15'd1023, 15'd0, 15'd0, 15'd0, 15'd0);
    push_random(FRAMES_PER_SETTING);
    // zero limit: every nonzero pair collapses to zero
    reprogram(15'd0, 15'd15, 15'd255, 15'd255, 15'd32760);
    push_frame(frame_of(12'd0, 0, 0));
    push_frame(frame_of(12'hFFF, 32767, -32768));
    push_random(FRAMES_PER_SETTING);
    reprogram(15'd1, 15'd1, 15'd128, 15'd1, 15'h7FFF);
    push_random(FRAMES_PER_SETTING);
    // random settings, upper data bits of the narrow registers included
    for (int p = 0; p < 3; p++) begin
      reprogram(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 20000)));
      push_random(FRAMES_PER_SETTING);
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.expected_speeds.size() != 0) sb.report("results still outstanding at the end");
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
